@@ src/itfs_pkg.sv @@
// Shared types and constants for the integer text field scanner.
// No dependencies; every other file imports this package.
package itfs_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int FIELD_LIMIT = 38;
  localparam int CNT_W       = $clog2(FIELD_LIMIT + 1);
  localparam int PROD_W      = VALUE_BITS + 5;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int OUT_VALUE_W = 32;
  localparam int STATUS_W    = 2;
  localparam int CHARS_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd2;

  localparam logic [VALUE_BITS-1:0] VAL_SMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_SMIN = ~VAL_SMAX;
  localparam logic [VALUE_BITS-1:0] VAL_UMAX = '1;

  // mode register encoding doubles as the working radix
  typedef enum logic [1:0] {MODE_AUTO, MODE_OCT, MODE_DEC, MODE_HEX} base_t;

  typedef enum logic [1:0] {ST_OK, ST_NO_DIGITS, ST_EOF} status_t;

  typedef enum logic [2:0] {
    K_WS, K_ZERO, K_DEC, K_HEX, K_SIGN, K_X, K_OTHER, K_END
  } kind_t;

  typedef enum logic [1:0] {LK_NONE, LK_SIGN, LK_X} lastkind_t;

  typedef enum logic {PH_SKIP, PH_FIELD} phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       minus;
  } item_t;

  typedef struct packed {
    base_t                 cb;
    logic                  sa;
    logic                  nd;
    logic                  nz;
    logic                  pa;
    logic [CNT_W-1:0]      cnt;
    logic [VALUE_BITS-1:0] mag;
    logic                  ovf;
    logic                  neg;
    lastkind_t             lk;
  } field_t;

  typedef struct packed {
    logic                  eof;
    logic                  nd;
    logic [CNT_W-1:0]      cnt;
    logic                  xback;
    logic                  ovf;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic                  by_width;
  } snap_t;

endpackage

@@ src/itfs_intf.sv @@
// Channel interfaces: character stream in, scanned field results out.
// Depends on itfs_pkg for payload widths.
interface itfs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink (input valid, ch, end_of_input, output ready);
endinterface

interface itfs_field_if import itfs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_VALUE_W-1:0] value;
  logic [STATUS_W-1:0]    status;
  logic [CHARS_W-1:0]     chars_taken;
  logic                   pushed_back;
  logic                   ended_by_width;

  modport source (output valid, value, status, chars_taken, pushed_back, ended_by_width,
                  input ready);
  modport sink (input valid, value, status, chars_taken, pushed_back, ended_by_width,
                output ready);
endinterface

@@ src/itfs_front.sv @@
// Front end: accepts characters, classifies them and queues them.
// Depends on itfs_pkg and itfs_char_if.
module itfs_front import itfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  itfs_char_if.sink   text,
  input  logic        pop,
  output logic        head_valid,
  output item_t       head
);

  item_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 push;
  item_t                cls;

  assign text.ready = !rst && (count != Q_CNT_W'(Q_DEPTH));
  assign push       = text.valid && text.ready;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    cls.kind  = K_OTHER;
    cls.digit = '0;
    cls.minus = 1'b0;
    if (text.end_of_input) begin
      cls.kind = K_END;
    end else if (text.ch == 8'h20 || text.ch inside {[8'h09:8'h0d]}) begin
      cls.kind = K_WS;
    end else if (text.ch == 8'h30) begin
      cls.kind = K_ZERO;
    end else if (text.ch inside {[8'h31:8'h39]}) begin
      cls.kind  = K_DEC;
      cls.digit = 4'(text.ch - 8'h30);
    end else if (text.ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      cls.kind  = K_HEX;
      cls.digit = 4'((text.ch | 8'h20) - 8'h57);
    end else if (text.ch == 8'h2b || text.ch == 8'h2d) begin
      cls.kind  = K_SIGN;
      cls.minus = (text.ch == 8'h2d);
    end else if (text.ch == 8'h78 || text.ch == 8'h58) begin
      cls.kind = K_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH)) else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");

endmodule

@@ src/itfs_back.sv @@
// Scan engine: one queued character per cycle through the field state machine, unless the snapshot stalls.
// Depends on itfs_pkg; feeds the result formatter through a snapshot register.
module itfs_back import itfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  item_t       head,
  output logic        pop,
  input  base_t       base_mode,
  input  logic [5:0]  max_width,
  input  logic        snap_ready,
  output logic        snap_valid,
  output snap_t       snap
);

  phase_t              phase;
  phase_t              phase_next;
  field_t              fs;
  field_t              fs_next;
  field_t              fresh;
  field_t              eff;
  field_t              nxt;
  logic                acc;
  logic                do_add;
  logic                emit;
  logic                load;
  snap_t               snap_next;
  logic [CNT_W-1:0]    lim;
  logic [PROD_W-1:0]   mag_x;
  logic [PROD_W-1:0]   scaled;
  logic [PROD_W-1:0]   prod;

  function automatic snap_t to_snap(field_t f, logic by_width);
    snap_t s;
    s.eof      = 1'b0;
    s.nd       = f.nd;
    s.cnt      = f.cnt;
    s.xback    = (f.lk == LK_X);
    s.ovf      = f.ovf;
    s.neg      = f.neg;
    s.mag      = f.mag;
    s.by_width = by_width;
    return s;
  endfunction

  assign pop  = head_valid && (!snap_valid || snap_ready);
  assign load = pop && emit;

  always_comb begin
    if (max_width == '0 || max_width > 6'(FIELD_LIMIT)) begin
      lim = CNT_W'(FIELD_LIMIT);
    end else begin
      lim = CNT_W'(max_width);
    end
  end

  always_comb begin
    fresh     = '0;
    fresh.cb  = base_mode;
    fresh.sa  = 1'b1;
    fresh.nd  = 1'b1;
    fresh.nz  = 1'b1;
    fresh.pa  = (base_mode == MODE_HEX);
    fresh.lk  = LK_NONE;
    eff       = (phase == PH_SKIP) ? fresh : fs;
    nxt       = eff;
    acc       = 1'b0;
    do_add    = 1'b0;

    case (head.kind)
      K_ZERO: begin
        if (eff.cb == MODE_AUTO) begin
          nxt.cb = MODE_OCT;
          nxt.pa = 1'b1;
        end
        if (eff.nz) begin
          nxt.nz = 1'b0;
        end else begin
          nxt.pa = 1'b0;
        end
        do_add = 1'b1;
      end
      K_DEC: begin
        if (eff.cb == MODE_AUTO) begin
          nxt.cb = MODE_DEC;
        end
        if (!(head.digit >= 4'd8 && nxt.cb == MODE_OCT)) begin
          nxt.pa = 1'b0;
          do_add = 1'b1;
        end
      end
      K_HEX: begin
        if (eff.cb == MODE_HEX) begin
          nxt.pa = 1'b0;
          do_add = 1'b1;
        end
      end
      K_SIGN: begin
        if (eff.sa) begin
          nxt.sa  = 1'b0;
          nxt.neg = head.minus;
          nxt.lk  = LK_SIGN;
          acc     = 1'b1;
        end
      end
      K_X: begin
        if (eff.pa && !eff.nd) begin
          nxt.cb = MODE_HEX;
          nxt.pa = 1'b0;
          nxt.lk = LK_X;
          acc    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // mag * radix + digit; overflow when anything lands above the value width
    mag_x = PROD_W'(eff.mag);
    case (nxt.cb)
      MODE_OCT: scaled = mag_x << 3;
      MODE_HEX: scaled = mag_x << 4;
      default:  scaled = (mag_x << 3) + (mag_x << 1);
    endcase
    prod = scaled + PROD_W'(head.digit);

    if (do_add) begin
      acc    = 1'b1;
      nxt.sa = 1'b0;
      nxt.nd = 1'b0;
      nxt.lk = LK_NONE;
      if (!eff.ovf) begin
        if (|prod[PROD_W-1:VALUE_BITS]) begin
          nxt.ovf = 1'b1;
        end else begin
          nxt.mag = prod[VALUE_BITS-1:0];
        end
      end
    end
    if (acc) begin
      nxt.cnt = eff.cnt + 1'b1;
    end

    emit       = 1'b0;
    snap_next  = '0;
    phase_next = phase;
    fs_next    = fs;
    if (phase == PH_SKIP && head.kind == K_END) begin
      emit          = 1'b1;
      snap_next.eof = 1'b1;
    end else if (phase == PH_SKIP && head.kind == K_WS) begin
      phase_next = PH_SKIP;
    end else if (!acc) begin
      emit       = 1'b1;
      snap_next  = to_snap(eff, 1'b0);
      phase_next = PH_SKIP;
    end else if (nxt.cnt >= lim) begin
      emit       = 1'b1;
      snap_next  = to_snap(nxt, 1'b1);
      phase_next = PH_SKIP;
    end else begin
      phase_next = PH_FIELD;
      fs_next    = nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SKIP;
    end else if (pop) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fs <= fs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (!snap_valid || snap_ready) begin
      snap_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= snap_next;
    end
  end

  a_width_end: assert property (@(posedge clk) disable iff (rst)
    (load && snap_next.by_width) |-> (snap_next.cnt >= lim))
    else $error("width end with wrong count");

  a_field_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FIELD) |-> (fs.cnt != '0)) else $error("open field holds no characters");

endmodule

@@ src/itfs_format.sv @@
// Result formatter: applies saturation, sign and pushback to a field snapshot.
// Depends on itfs_pkg and itfs_field_if; holds the output register.
module itfs_format import itfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        snap_valid,
  input  snap_t       snap,
  input  logic        signed_conversion,
  output logic        snap_ready,
  itfs_field_if.source result
);

  logic                   out_valid;
  logic [OUT_VALUE_W-1:0] value_r;
  status_t                status_r;
  logic [CHARS_W-1:0]     chars_r;
  logic                   pushed_r;
  logic                   width_r;

  logic [VALUE_BITS-1:0]  val;
  logic [VALUE_BITS-1:0]  neg_mag;
  status_t                st;
  logic                   pushed;
  logic [CNT_W-1:0]       count;

  assign snap_ready            = !out_valid || result.ready;
  assign result.valid          = out_valid;
  assign result.value          = value_r;
  assign result.status         = status_r;
  assign result.chars_taken    = chars_r;
  assign result.pushed_back    = pushed_r;
  assign result.ended_by_width = width_r;

  always_comb begin
    neg_mag = '0 - snap.mag;
    val     = '0;
    st      = ST_OK;
    pushed  = 1'b0;
    if (snap.eof) begin
      st = ST_EOF;
    end else if (snap.nd) begin
      st     = ST_NO_DIGITS;
      pushed = (snap.cnt != '0);
    end else begin
      pushed = snap.xback;
      if (signed_conversion) begin
        if (snap.neg) begin
          val = (snap.ovf || snap.mag > VAL_SMIN) ? VAL_SMIN : neg_mag;
        end else begin
          val = (snap.ovf || snap.mag > VAL_SMAX) ? VAL_SMAX : snap.mag;
        end
      end else if (snap.ovf) begin
        val = VAL_UMAX;
      end else begin
        val = snap.neg ? neg_mag : snap.mag;
      end
    end
    count = snap.cnt - CNT_W'(pushed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      value_r  <= OUT_VALUE_W'(val);
      status_r <= st;
      chars_r  <= CHARS_W'(count);
      pushed_r <= pushed;
      width_r  <= snap.by_width;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_r != ST_OK) |-> (value_r == '0))
    else $error("failed field carries a value");

  a_eof_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_r == ST_EOF) |-> (chars_r == '0 && !pushed_r && !width_r))
    else $error("end-of-input result not empty");

endmodule

@@ src/integer_text_field_scanner.sv @@
// Integer text field scanner: one character per cycle if unstalled, one result per field.
// Throughput 1 character per clock unless the output stalls; the scan engine handles
// one queued character a cycle. A field's result follows its closing character through
// the queue write, the scan engine snapshot and the output register; stalls hold it.
// Reset (rst, synchronous): registers to defaults, queue empty, skipping whitespace.
module integer_text_field_scanner import itfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  itfs_char_if.sink             text,
  itfs_field_if.source          result
);

  base_t       base_mode;
  logic        signed_conversion;
  logic [5:0]  max_width;

  logic        head_valid;
  item_t       head;
  logic        pop;
  logic        snap_valid;
  logic        snap_ready;
  snap_t       snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode         <= MODE_DEC;
      signed_conversion <= 1'b1;
      max_width         <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_MODE: base_mode         <= base_t'(cfg_data[1:0]);
        REG_SIGNED:    signed_conversion <= cfg_data[0];
        REG_MAX_WIDTH: max_width         <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  itfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  itfs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .base_mode  (base_mode),
    .max_width  (max_width),
    .snap_ready (snap_ready),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  itfs_format u_format (
    .clk               (clk),
    .rst               (rst),
    .snap_valid        (snap_valid),
    .snap              (snap),
    .signed_conversion (signed_conversion),
    .snap_ready        (snap_ready),
    .result            (result)
  );

endmodule
